@@ rtl/stop_loss_profit_take_exit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the stop-loss / profit-take exit block
// Shared concurrent assertion forms, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef STOP_LOSS_PROFIT_TAKE_EXIT_DEFINES_SVH
`define STOP_LOSS_PROFIT_TAKE_EXIT_DEFINES_SVH

// pre holds -> post holds in the same cycle
`define SLPTE_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("slpte: same-cycle check failed");

// pre holds -> post holds in the next cycle
`define SLPTE_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("slpte: next-cycle check failed");

`endif

@@ rtl/slpte_pkg.sv @@
// ----------------------------------------------------------------------------
// slpte_pkg
// Widths, reset values, register indexes and codes of the exit block.
// ----------------------------------------------------------------------------
package slpte_pkg;

   localparam int PRICE_W            = 32;
   localparam int IDX_W              = 20;
   localparam int LEVEL_W            = 18;
   localparam int COST_W             = 16;
   localparam int Q16_FRAC_W         = 16;
   localparam int CSR_DATA_W         = 18;
   localparam int CSR_INDEX_W        = 2;
   localparam int PRICE_BITS_DEFAULT = 32;

   // bar counter wraps to zero when it reaches this
   localparam logic [32:0] MAX_BARS = 33'd1048576;

   localparam logic [COST_W:0] Q16_ONE = 17'h10000;

   localparam logic [LEVEL_W-1:0] STOP_LOSS_RESET   = 18'h3F333; // -3277
   localparam logic [LEVEL_W-1:0] PROFIT_TAKE_RESET = 18'd6554;
   localparam logic [COST_W-1:0]  COST_RESET        = 16'd0;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STOP_LOSS     = 2'd0,
      CSR_PROFIT_TAKE   = 2'd1,
      CSR_COST_FRACTION = 2'd2
   } csr_index_type;

   typedef enum logic {
      SIDE_BUY  = 1'b0,
      SIDE_SELL = 1'b1
   } trade_side_type;

   // what one bar left in the result queue
   typedef enum logic [1:0] {
      KIND_BUY  = 2'd0,
      KIND_SELL = 2'd1,
      KIND_BOTH = 2'd2
   } trade_kind_type;

   typedef struct packed {
      trade_kind_type     kind;
      logic [IDX_W-1:0]   bar_index;
      logic [PRICE_W-1:0] trade_price;
   } queue_entry_type;

endpackage

@@ rtl/slpte_if.sv @@
// ----------------------------------------------------------------------------
// slpte channel interfaces
// Valid/ready channels for price bars in and trades out.
// ----------------------------------------------------------------------------
interface slpte_req_if import slpte_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               entry_signal;
   logic [PRICE_W-1:0] close_price;
   logic               series_last;

   modport source (output valid, output entry_signal, output close_price,
                   output series_last, input ready);
   modport sink   (input valid, input entry_signal, input close_price,
                   input series_last, output ready);
endinterface

interface slpte_rsp_if import slpte_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               trade_side;
   logic [IDX_W-1:0]   bar_index;
   logic [PRICE_W-1:0] trade_price;
   logic               run_last;

   modport source (output valid, output trade_side, output bar_index,
                   output trade_price, output run_last, input ready);
   modport sink   (input valid, input trade_side, input bar_index,
                   input trade_price, input run_last, output ready);
endinterface

@@ rtl/stop_loss_profit_take_exit.sv @@
// ----------------------------------------------------------------------------
// stop_loss_profit_take_exit
// Trade exit on stop-loss / profit-take levels over a stream of price bars.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one price bar per word: entry_signal, close_price,
//   series_last. rsp_ch carries trade words: trade_side, bar_index,
//   trade_price, run_last (set on the last trade a bar causes).
//   csr_* writes the stop-loss level, profit-take level and cost fraction;
//   write only while no bar is in flight and the result queue is drained.
//   Levels may change while a position is held; the entry cost stays as
//   it was at the buy.
// Path: a bar's first trade word goes through the input register, the
//   product register, then the queue write before rsp_ch.valid rises.
// Throughput: one bar per cycle while req_ch.ready stays high. A flat last
//   bar makes two trade words and holds the queue head for both, so a run
//   of them drains at one bar per two trade words.
// Stall: trades wait in a 4-deep queue; req_ch.ready drops once the queue
//   could not absorb every bar already in flight plus one more.
// Reset: position flat, bar counter zero, queue empty, levels at defaults.
`include "stop_loss_profit_take_exit_defines.svh"

module stop_loss_profit_take_exit import slpte_pkg::*; #(
   parameter int PRICE_BITS = PRICE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   slpte_req_if.sink              req_ch,
   slpte_rsp_if.source            rsp_ch,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // k = (1 + cost) * (1 + level) in Q16*Q16, threshold = entry price * k
   localparam int K_W    = COST_W + 1 + LEVEL_W;
   localparam int SELL_W = PRICE_BITS + COST_W + 1;
   localparam int THR_W  = PRICE_BITS + K_W;

   // ---------------- configuration ----------------
   logic [LEVEL_W-1:0] stop_loss_ff, stop_loss_in;
   logic [LEVEL_W-1:0] profit_take_ff, profit_take_in;
   logic [COST_W-1:0]  cost_ff, cost_in;

   always_comb begin
      stop_loss_in   = stop_loss_ff;
      profit_take_in = profit_take_ff;
      cost_in        = cost_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_STOP_LOSS:     stop_loss_in   = csr_write_data[LEVEL_W-1:0];
            CSR_PROFIT_TAKE:   profit_take_in = csr_write_data[LEVEL_W-1:0];
            CSR_COST_FRACTION: cost_in        = csr_write_data[COST_W-1:0];
            default: ;
         endcase
      end
   end

   // level + 1.0; a negative sum means the level sits below minus one
   logic signed [LEVEL_W:0] sl_mult_sum, pt_mult_sum;
   logic                    sl_neg, pt_neg;
   logic [COST_W:0]         buy_mul, sell_mul;
   logic [K_W-1:0]          k_sl_ff, k_sl_in, k_pt_ff, k_pt_in;

   assign sl_mult_sum = $signed({stop_loss_ff[LEVEL_W-1], stop_loss_ff})
                      + $signed((LEVEL_W+1)'(Q16_ONE));
   assign pt_mult_sum = $signed({profit_take_ff[LEVEL_W-1], profit_take_ff})
                      + $signed((LEVEL_W+1)'(Q16_ONE));
   assign sl_neg   = sl_mult_sum[LEVEL_W];
   assign pt_neg   = pt_mult_sum[LEVEL_W];
   assign buy_mul  = Q16_ONE + (COST_W+1)'(cost_ff);
   assign sell_mul = Q16_ONE - (COST_W+1)'(cost_ff);
   assign k_sl_in  = K_W'(buy_mul) * K_W'(sl_mult_sum[LEVEL_W-1:0]);
   assign k_pt_in  = K_W'(buy_mul) * K_W'(pt_mult_sum[LEVEL_W-1:0]);

   // ---------------- stage 1: input register ----------------
   logic                    req_fire;
   logic                    v1_ff;
   logic                    sig1_ff, last1_ff;
   logic [PRICE_BITS-1:0]   price1_ff, price1_in;
   logic [PRICE_BITS+PRICE_W-1:0] price_ext;

   assign req_fire  = req_ch.valid & req_ch.ready;
   assign price_ext = {{PRICE_BITS{1'b0}}, req_ch.close_price};
   assign price1_in = price_ext[PRICE_BITS-1:0];

   // ---------------- stage 2: products ----------------
   logic                  v2_ff, sig2_ff, last2_ff;
   logic [PRICE_BITS-1:0] price2_ff;
   logic [SELL_W-1:0]     sell_q2_ff, sell_q2_in;
   logic [THR_W-1:0]      cand_sl2_ff, cand_sl2_in, cand_pt2_ff, cand_pt2_in;

   assign sell_q2_in  = SELL_W'(price1_ff) * SELL_W'(sell_mul);
   assign cand_sl2_in = THR_W'(price1_ff) * THR_W'(k_sl_ff);
   assign cand_pt2_in = THR_W'(price1_ff) * THR_W'(k_pt_ff);

   // ---------------- position state and decision ----------------
   logic                  open_ff, open_in;
   logic [IDX_W-1:0]      bar_count_ff, bar_count_in;
   logic [PRICE_BITS-1:0] entry_price_ff, entry_price_in;
   logic [COST_W:0]       entry_mul_ff, entry_mul_in;
   logic [K_W-1:0]        kh_sl_ff, kh_sl_in, kh_pt_ff, kh_pt_in;
   logic [THR_W-1:0]      thr_sl_ff, thr_sl_in, thr_pt_ff, thr_pt_in;
   logic [IDX_W:0]        bar_next;
   logic [THR_W-1:0]      sell_lhs;
   logic                  hit_sl, hit_pt;
   logic                  push;
   trade_kind_type        push_kind;
   logic [PRICE_BITS+PRICE_W-1:0] price_out_ext;

   assign bar_next = {1'b0, bar_count_ff} + (IDX_W+1)'(1);
   assign sell_lhs = THR_W'({sell_q2_ff, {Q16_FRAC_W{1'b0}}});
   assign hit_sl   = !sl_neg && (sell_lhs <= thr_sl_ff);
   assign hit_pt   = pt_neg || (sell_lhs >= thr_pt_ff);
   assign price_out_ext = {{PRICE_W{1'b0}}, price2_ff};

   // held position: cost multiplier from the buy, levels as they stand now
   assign kh_sl_in = K_W'(entry_mul_in) * K_W'(sl_mult_sum[LEVEL_W-1:0]);
   assign kh_pt_in = K_W'(entry_mul_in) * K_W'(pt_mult_sum[LEVEL_W-1:0]);

   always_comb begin
      push           = 1'b0;
      push_kind      = KIND_SELL;
      open_in        = open_ff;
      bar_count_in   = bar_count_ff;
      entry_price_in = entry_price_ff;
      entry_mul_in   = entry_mul_ff;
      // thresholds follow the current levels, cost stays at its entry value
      thr_sl_in      = THR_W'(entry_price_ff) * THR_W'(kh_sl_ff);
      thr_pt_in      = THR_W'(entry_price_ff) * THR_W'(kh_pt_ff);
      if (v2_ff) begin
         if (last2_ff) begin
            push         = 1'b1;
            push_kind    = open_ff ? KIND_SELL : KIND_BOTH;
            open_in      = 1'b0;
            bar_count_in = '0;
         end else begin
            if (33'(bar_next) >= MAX_BARS) begin
               bar_count_in = '0;
            end else begin
               bar_count_in = bar_next[IDX_W-1:0];
            end
            if (open_ff) begin
               if (hit_sl || hit_pt) begin
                  push      = 1'b1;
                  push_kind = KIND_SELL;
                  open_in   = 1'b0;
               end
            end else if (sig2_ff) begin
               push           = 1'b1;
               push_kind      = KIND_BUY;
               open_in        = 1'b1;
               entry_price_in = price2_ff;
               entry_mul_in   = buy_mul;
               thr_sl_in      = cand_sl2_ff;
               thr_pt_in      = cand_pt2_ff;
            end
         end
      end
   end

   // ---------------- result queue: at most one entry per bar ----------------
   queue_entry_type       queue_ff [QUEUE_DEPTH];
   queue_entry_type       push_entry, head;
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  phase_ff, phase_in;
   logic                  rsp_fire, pop;
   logic [CNT_W:0]        room_need;

   assign push_entry.kind        = push_kind;
   assign push_entry.bar_index   = bar_count_ff;
   assign push_entry.trade_price = price_out_ext[PRICE_W-1:0];

   assign head     = queue_ff[rd_ptr_ff];
   assign rsp_fire = rsp_ch.valid & rsp_ch.ready;
   assign pop      = rsp_fire && ((head.kind != KIND_BOTH) || phase_ff);

   assign wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
   assign count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   assign phase_in  = rsp_fire ? ((head.kind == KIND_BOTH) && !phase_ff) : phase_ff;

   // every bar in flight may still need one entry
   assign room_need = {1'b0, count_ff} + (CNT_W+1)'(v1_ff) + (CNT_W+1)'(v2_ff)
                    + (CNT_W+1)'(1);
   assign req_ch.ready = (room_need <= (CNT_W+1)'(QUEUE_DEPTH));

   assign rsp_ch.valid       = (count_ff != '0);
   assign rsp_ch.bar_index   = head.bar_index;
   assign rsp_ch.trade_price = head.trade_price;

   always_comb begin
      case (head.kind)
         KIND_BUY: begin
            rsp_ch.trade_side = SIDE_BUY;
            rsp_ch.run_last   = 1'b1;
         end
         KIND_SELL: begin
            rsp_ch.trade_side = SIDE_SELL;
            rsp_ch.run_last   = 1'b1;
         end
         KIND_BOTH: begin
            // buy first, then the closing sell of the same bar
            rsp_ch.trade_side = phase_ff ? SIDE_SELL : SIDE_BUY;
            rsp_ch.run_last   = phase_ff;
         end
         default: begin
            rsp_ch.trade_side = SIDE_SELL;
            rsp_ch.run_last   = 1'b1;
         end
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         stop_loss_ff   <= STOP_LOSS_RESET;
         profit_take_ff <= PROFIT_TAKE_RESET;
         cost_ff        <= COST_RESET;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         open_ff        <= 1'b0;
         bar_count_ff   <= '0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
         phase_ff       <= 1'b0;
      end else begin
         stop_loss_ff   <= stop_loss_in;
         profit_take_ff <= profit_take_in;
         cost_ff        <= cost_in;
         v1_ff          <= req_fire;
         v2_ff          <= v1_ff;
         open_ff        <= open_in;
         bar_count_ff   <= bar_count_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         count_ff       <= count_in;
         phase_ff       <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      k_sl_ff        <= k_sl_in;
      k_pt_ff        <= k_pt_in;
      if (req_fire) begin
         sig1_ff   <= req_ch.entry_signal;
         last1_ff  <= req_ch.series_last;
         price1_ff <= price1_in;
      end
      sig2_ff        <= sig1_ff;
      last2_ff       <= last1_ff;
      price2_ff      <= price1_ff;
      sell_q2_ff     <= sell_q2_in;
      cand_sl2_ff    <= cand_sl2_in;
      cand_pt2_ff    <= cand_pt2_in;
      entry_price_ff <= entry_price_in;
      entry_mul_ff   <= entry_mul_in;
      kh_sl_ff       <= kh_sl_in;
      kh_pt_ff       <= kh_pt_in;
      thr_sl_ff      <= thr_sl_in;
      thr_pt_ff      <= thr_pt_in;
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // ---------------- assertions ----------------
   `SLPTE_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   `SLPTE_ASSERT_NOW(a_no_overflow, clock, reset, push, (count_ff < CNT_W'(QUEUE_DEPTH)) || pop)
   `SLPTE_ASSERT_NEXT(a_last_closes, clock, reset, v2_ff && last2_ff, !open_ff && (bar_count_ff == '0))
   `SLPTE_ASSERT_NOW(a_phase_pair, clock, reset, phase_ff, rsp_ch.valid && (head.kind == KIND_BOTH))

endmodule
